[hdl/qrs_pkg.sv]
// shared types, widths and helpers for the quadratic root solver
package qrs_pkg;

  localparam int COEF_W    = 32;
  localparam int TOL_W     = 16;
  localparam int ROOT_W    = 64;
  localparam int OUT_FRAC  = 32;
  localparam int SQ_W      = COEF_W + 2;
  localparam int D_W       = 2 * SQ_W;
  localparam int NUM_W     = SQ_W + 1;
  localparam int DEN_W     = COEF_W + 1;
  localparam int QUO_W     = NUM_W + OUT_FRAC;
  localparam int SQ_QUO_W  = QUO_W + 1;
  localparam int SUM_W     = QUO_W + 3;

  typedef enum logic [2:0] {
    CASE_ALL    = 3'd0,
    CASE_NONE   = 3'd1,
    CASE_LINEAR = 3'd2,
    CASE_NOREAL = 3'd3,
    CASE_TWO    = 3'd4,
    CASE_DOUBLE = 3'd5
  } root_case_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    root_case_t               root_case;
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;
    logic                     saturated;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                az;
    logic                bz;
    logic                cz;
    logic                sa;
    logic                sb;
    logic                sc;
    logic [COEF_W-1:0]   am;
    logic [COEF_W-1:0]   bm;
    logic [COEF_W-1:0]   cm;
    logic [2*COEF_W-1:0] b2;
    logic [2*COEF_W-1:0] ac;
  } front_t;

  // sideband carried through the square root
  typedef struct packed {
    root_case_t        kase;
    logic              sa;
    logic              sb;
    logic [COEF_W-1:0] am;
    logic [COEF_W-1:0] bm;
    logic [COEF_W-1:0] num2;
    logic [COEF_W-1:0] den2;
    logic              neg2;
  } sq_tag_t;

  typedef struct packed {
    root_case_t kase;
    logic       neg1;
  } div_tag_t;

  // clip to signed 64 bit, msb of result is the clip flag
  function automatic logic [ROOT_W:0] sat_root(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-ROOT_W:0] top;
    top = x[SUM_W-1:ROOT_W-1];
    if (top == '0 || top == '1) begin
      return {1'b0, x[ROOT_W-1:0]};
    end else if (x[SUM_W-1]) begin
      return {1'b1, 1'b1, {(ROOT_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(ROOT_W-1){1'b1}}};
    end
  endfunction

endpackage

[hdl/qrs_front.sv]
// front: splits coefficients, applies the zero tolerance, forms b*b and a*c
module qrs_front import qrs_pkg::*; #(
  parameter int COEF_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_t              in_data,
  input  logic [TOL_W-1:0] tol,
  output logic             out_valid,
  output front_t           out_data
);

  localparam int SH = COEF_W - COEF_BITS;

  function automatic logic [COEF_W:0] split(input logic signed [COEF_W-1:0] raw);
    logic signed [COEF_W-1:0] up;
    logic signed [COEF_W-1:0] ext;
    up  = raw <<< SH;
    ext = up >>> SH;
    if (ext[COEF_W-1]) begin
      return {1'b1, ~ext + COEF_W'(1)};
    end else begin
      return {1'b0, ext};
    end
  endfunction

  logic [COEF_W:0] sa_w, sb_w, sc_w;
  logic [COEF_W-1:0] tol_ext;

  logic                v1_r;
  logic                az_r, bz_r, cz_r, sa_r, sb_r, sc_r;
  logic [COEF_W-1:0]   am_r, bm_r, cm_r;
  logic                v2_r;
  front_t              f_r;

  assign sa_w    = split(in_data.coef_a);
  assign sb_w    = split(in_data.coef_b);
  assign sc_w    = split(in_data.coef_c);
  assign tol_ext = {{(COEF_W-TOL_W){1'b0}}, tol};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= sa_w[COEF_W];
    sb_r <= sb_w[COEF_W];
    sc_r <= sc_w[COEF_W];
    am_r <= sa_w[COEF_W-1:0];
    bm_r <= sb_w[COEF_W-1:0];
    cm_r <= sc_w[COEF_W-1:0];
    az_r <= (sa_w[COEF_W-1:0] <= tol_ext);
    bz_r <= (sb_w[COEF_W-1:0] <= tol_ext);
    cz_r <= (sc_w[COEF_W-1:0] <= tol_ext);
  end

  always_ff @(posedge clk) begin
    f_r.az <= az_r;
    f_r.bz <= bz_r;
    f_r.cz <= cz_r;
    f_r.sa <= sa_r;
    f_r.sb <= sb_r;
    f_r.sc <= sc_r;
    f_r.am <= am_r;
    f_r.bm <= bm_r;
    f_r.cm <= cm_r;
    f_r.b2 <= bm_r * bm_r;
    f_r.ac <= am_r * cm_r;
  end

  assign out_valid = v2_r;
  assign out_data  = f_r;

endmodule

[hdl/qrs_fifo.sv]
// two-entry item queue between front and back
module qrs_fifo import qrs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  front_t push_data,
  output logic   full,
  output logic   pop_valid,
  output front_t pop_data
);

  front_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = (count_r != 2'd0);
  assign pop_valid = pop;
  assign pop_data  = mem_r[rd_ptr_r];
  assign full      = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/qrs_isqrt.sv]
// pipelined floor square root, one root bit per stage
module qrs_isqrt import qrs_pkg::*; #(
  parameter int RW    = 34,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  logic              v_r    [RW];
  logic [2*RW-1:0]   rad_r  [RW];
  logic [RW+1:0]     rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [TAG_W-1:0]  tag_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic             v_p;
    logic [2*RW-1:0]  rad_p;
    logic [RW+1:0]    rem_p;
    logic [RW-1:0]    root_p;
    logic [TAG_W-1:0] tag_p;
    logic [RW+1:0]    rem_t;
    logic [RW+1:0]    trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = in_tag;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign rad_p  = rad_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign tag_p  = tag_r[i-1];
    end

    assign rem_t = {rem_p[RW-1:0], rad_p[2*RW-1:2*RW-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i]  <= rad_p << 2;
      rem_r[i]  <= ge ? (rem_t - trial) : rem_t;
      root_r[i] <= {root_p[RW-2:0], ge};
      tag_r[i]  <= tag_p;
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule

[hdl/qrs_div.sv]
// pipelined unsigned restoring divider, numerator scaled by 2^OUT_FRAC
module qrs_div import qrs_pkg::*; #(
  parameter int NW    = 35,
  parameter int DW    = 33,
  parameter int TAG_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [NW+OUT_FRAC-1:0] out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int TOT = NW + OUT_FRAC;

  logic             v_r   [TOT];
  logic [TOT-1:0]   num_r [TOT];
  logic [TOT-1:0]   quo_r [TOT];
  logic [DW-1:0]    rem_r [TOT];
  logic [DW-1:0]    den_r [TOT];
  logic [TAG_W-1:0] tag_r [TOT];

  for (genvar i = 0; i < TOT; i++) begin : g_stage
    logic             v_p;
    logic [TOT-1:0]   num_p;
    logic [TOT-1:0]   quo_p;
    logic [DW-1:0]    rem_p;
    logic [DW-1:0]    den_p;
    logic [TAG_W-1:0] tag_p;
    logic [DW:0]      rt;
    logic [DW:0]      diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_p   = in_valid;
      assign num_p = {in_num, {OUT_FRAC{1'b0}}};
      assign quo_p = '0;
      assign rem_p = '0;
      assign den_p = in_den;
      assign tag_p = in_tag;
    end else begin : g_next
      assign v_p   = v_r[i-1];
      assign num_p = num_r[i-1];
      assign quo_p = quo_r[i-1];
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign tag_p = tag_r[i-1];
    end

    assign rt   = {rem_p, num_p[TOT-1]};
    assign diff = rt - {1'b0, den_p};
    assign ge   = (rt >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      num_r[i] <= num_p << 1;
      quo_r[i] <= {quo_p[TOT-2:0], ge};
      rem_r[i] <= ge ? diff[DW-1:0] : rt[DW-1:0];
      den_r[i] <= den_p;
      tag_r[i] <= tag_p;
    end
  end

  assign out_valid = v_r[TOT-1];
  assign out_quo   = quo_r[TOT-1];
  assign out_tag   = tag_r[TOT-1];

endmodule

[hdl/qrs_back.sv]
// back: discriminant, case choice, square root, divisions and clipping
module qrs_back import qrs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output out_t   out_data
);

  // discriminant stage
  logic [2*COEF_W+1:0]  ac4;
  logic signed [D_W-1:0] d_w;
  root_case_t           kase_w;
  sq_tag_t              tag_w;

  logic                 d_v_r;
  logic [D_W-1:0]       d_r;
  sq_tag_t              d_tag_r;

  assign ac4 = {in_data.ac, 2'b00};
  assign d_w = (in_data.sa == in_data.sc)
             ? $signed({4'b0, in_data.b2} - {2'b0, ac4})
             : $signed({4'b0, in_data.b2} + {2'b0, ac4});

  always_comb begin
    if (in_data.az) begin
      if (in_data.bz) begin
        kase_w = in_data.cz ? CASE_ALL : CASE_NONE;
      end else begin
        kase_w = CASE_LINEAR;
      end
    end else if (d_w[D_W-1]) begin
      kase_w = CASE_NOREAL;
    end else if (d_w == '0) begin
      kase_w = CASE_DOUBLE;
    end else begin
      kase_w = CASE_TWO;
    end
  end

  always_comb begin
    tag_w.kase = kase_w;
    tag_w.sa   = in_data.sa;
    tag_w.sb   = in_data.sb;
    tag_w.am   = in_data.am;
    tag_w.bm   = in_data.bm;
    // -c/b for the linear case, b/a otherwise
    if (kase_w == CASE_LINEAR) begin
      tag_w.num2 = in_data.cm;
      tag_w.den2 = in_data.bm;
      tag_w.neg2 = ~in_data.sc ^ in_data.sb;
    end else begin
      tag_w.num2 = in_data.bm;
      tag_w.den2 = in_data.am;
      tag_w.neg2 = in_data.sb ^ in_data.sa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_w;
    d_tag_r <= tag_w;
  end

  // square root
  logic                      sq_v;
  logic [SQ_W-1:0]           sq_root;
  logic [$bits(sq_tag_t)-1:0] sq_tag_bits;
  sq_tag_t                   sq_tag;

  qrs_isqrt #(
    .RW    (SQ_W),
    .TAG_W ($bits(sq_tag_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_v_r),
    .in_rad    (d_r),
    .in_tag    (d_tag_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag_bits)
  );

  assign sq_tag = sq_tag_t'(sq_tag_bits);

  // numerator sqrt(D) - b, signed
  logic signed [SQ_W+1:0] n1;
  logic [SQ_W+1:0]        n1_neg;
  logic [NUM_W-1:0]       num1;
  div_tag_t               dt1;

  always_comb begin
    if (sq_tag.sb) begin
      n1 = $signed({2'b0, sq_root} + {4'b0, sq_tag.bm});
    end else begin
      n1 = $signed({2'b0, sq_root} - {4'b0, sq_tag.bm});
    end
    n1_neg    = -n1;
    num1      = n1[SQ_W+1] ? n1_neg[NUM_W-1:0] : n1[NUM_W-1:0];
    dt1.kase  = sq_tag.kase;
    dt1.neg1  = n1[SQ_W+1] ^ sq_tag.sa;
  end

  logic                        dv1, dv2;
  logic [QUO_W-1:0]            q1, q2;
  logic [$bits(div_tag_t)-1:0] dt1_out;
  logic                        neg2_out;
  div_tag_t                    dt1_q;

  qrs_div #(
    .NW    (NUM_W),
    .DW    (DEN_W),
    .TAG_W ($bits(div_tag_t))
  ) u_div_x1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_num    (num1),
    .in_den    ({sq_tag.am, 1'b0}),
    .in_tag    (dt1),
    .out_valid (dv1),
    .out_quo   (q1),
    .out_tag   (dt1_out)
  );

  qrs_div #(
    .NW    (NUM_W),
    .DW    (DEN_W),
    .TAG_W (1)
  ) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_num    ({{(NUM_W-COEF_W){1'b0}}, sq_tag.num2}),
    .in_den    ({1'b0, sq_tag.den2}),
    .in_tag    (sq_tag.neg2),
    .out_valid (dv2),
    .out_quo   (q2),
    .out_tag   (neg2_out)
  );

  assign dt1_q = div_tag_t'(dt1_out);

  // apply signs
  logic                       e1_v_r;
  root_case_t                 e1_kase_r;
  logic signed [SQ_QUO_W-1:0] x1_r, q2_r;
  logic [SQ_QUO_W-1:0]        q1_ext, q2_ext;

  assign q1_ext = {1'b0, q1};
  assign q2_ext = {1'b0, q2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else begin
      e1_v_r <= dv1 & dv2;
    end
  end

  always_ff @(posedge clk) begin
    e1_kase_r <= dt1_q.kase;
    x1_r      <= dt1_q.neg1 ? -$signed(q1_ext) : $signed(q1_ext);
    q2_r      <= neg2_out ? -$signed(q2_ext) : $signed(q2_ext);
  end

  // second root and clipping
  logic signed [SUM_W-1:0] x1_w, q2_w, x2_w;
  logic [ROOT_W:0]         s1, s2, sl;
  out_t                    res_w;
  logic                    out_v_r;
  out_t                    out_r;

  assign x1_w = SUM_W'(x1_r);
  assign q2_w = SUM_W'(q2_r);
  assign x2_w = -x1_w - q2_w;
  assign s1   = sat_root(x1_w);
  assign s2   = sat_root(x2_w);
  assign sl   = sat_root(q2_w);

  always_comb begin
    res_w.root_case = e1_kase_r;
    res_w.root_one  = '0;
    res_w.root_two  = '0;
    res_w.saturated = 1'b0;
    case (e1_kase_r)
      CASE_LINEAR: begin
        res_w.root_one  = sl[ROOT_W-1:0];
        res_w.saturated = sl[ROOT_W];
      end
      CASE_DOUBLE: begin
        res_w.root_one  = s1[ROOT_W-1:0];
        res_w.saturated = s1[ROOT_W];
      end
      CASE_TWO: begin
        res_w.root_one  = s1[ROOT_W-1:0];
        res_w.root_two  = s2[ROOT_W-1:0];
        res_w.saturated = s1[ROOT_W] | s2[ROOT_W];
      end
      default: begin
        res_w.root_one = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_w;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hdl/quadratic_root_solver.sv]
// quadratic root solver: one coefficient triple per cycle
// the path runs through the 34-stage square root, then the two 67-stage dividers in parallel
// throughput one item per clock; busy stays low since the back never stalls
// results are strobed on out_valid for exactly one cycle
// synchronous active-low reset clears all valid bits and zero_tolerance to 0
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  logic [TOL_W-1:0] tol_r;
  logic             accept;
  logic             f_valid;
  front_t           f_data;
  logic             q_full;
  logic             q_valid;
  front_t           q_data;

  assign accept = start & ~busy;
  assign busy   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  qrs_front #(
    .COEF_BITS (COEF_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .tol       (tol_r),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  qrs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  qrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_data   (q_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // back drains one item per cycle so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("item queue filled");

  a_root_two_only_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_case != CASE_TWO |-> out_data.root_two == '0)
    else $error("second root set outside two-root case");

  a_no_root_cases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_case == CASE_ALL || out_data.root_case == CASE_NONE ||
                  out_data.root_case == CASE_NOREAL)
    |-> out_data.root_one == '0 && !out_data.saturated)
    else $error("root or clip flag set where no root exists");

endmodule
